FILE: rtl/core/health_flap_detector_defines.svh
// ----------------------------------------------------------------------------
// Health flap detector assertion macros
// Shared concurrent assertion shorthands for the detector's RTL files.
// ----------------------------------------------------------------------------
`ifndef HEALTH_FLAP_DETECTOR_DEFINES_SVH
`define HEALTH_FLAP_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hfd assertion failed");

`endif

FILE: rtl/core/hfd_pkg.sv
// ----------------------------------------------------------------------------
// Health flap detector package
// State codes, register indexes, reset constants and controller interface types.
// ----------------------------------------------------------------------------
package hfd_pkg;

	localparam int MAX_CHANGES_DEF = 16;
	localparam logic [15:0] WINDOW_RESET = 16'd300;
	localparam logic [4:0] THRESHOLD_RESET = 5'd2;

	typedef enum logic [2:0] {
		ST_UNKNOWN   = 3'd0,
		ST_UP        = 3'd1,
		ST_DOWN      = 3'd2,
		ST_FAST_FLAP = 3'd3,
		ST_SLOW_FLAP = 3'd4
	} hstate_t;

	typedef enum logic [0:0] {
		REG_WINDOW    = 1'b0,
		REG_THRESHOLD = 1'b1
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic prune_rd;
		logic prune_pop;
		logic scan_rd;
		logic scan_step;
		logic store;
		logic out_load;
	} hfd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic changed;
		logic count_zero;
		logic older;
		logic scan_more;
	} hfd_status_t;

	// Round state from the two probe summary bits.
	function automatic hstate_t derive_state(logic up, logic down);
		hstate_t s;
		if (up && down) begin
			s = ST_FAST_FLAP;
		end else if (up) begin
			s = ST_UP;
		end else if (down) begin
			s = ST_DOWN;
		end else begin
			s = ST_UNKNOWN;
		end
		return s;
	endfunction

endpackage

FILE: rtl/core/hfd_in_if.sv
// ----------------------------------------------------------------------------
// Health flap detector input channel
// Valid/ready channel carrying one check round per item.
// ----------------------------------------------------------------------------
interface hfd_in_if;
	logic        valid;
	logic        ready;
	logic        any_up;
	logic        any_down;
	logic [31:0] now_seconds;

	modport source (output valid, output any_up, output any_down, output now_seconds,
		input ready);
	modport sink (input valid, input any_up, input any_down, input now_seconds,
		output ready);
endinterface

FILE: rtl/core/hfd_out_if.sv
// ----------------------------------------------------------------------------
// Health flap detector output channel
// Valid/ready channel carrying one round result per item.
// ----------------------------------------------------------------------------
interface hfd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] health_state;
	logic       report_valid;
	logic [2:0] report_from;
	logic [2:0] report_to;
	logic [4:0] changes_in_window;

	modport source (output valid, output health_state, output report_valid,
		output report_from, output report_to, output changes_in_window, input ready);
	modport sink (input valid, input health_state, input report_valid,
		input report_from, input report_to, input changes_in_window, output ready);
endinterface

FILE: rtl/core/hfd_ctrl.sv
// ----------------------------------------------------------------------------
// Health flap detector controller
// Sequences accept, prune, duplicate scan, store and result hand-off.
// ----------------------------------------------------------------------------
module hfd_ctrl
	import hfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  hfd_status_t status,
	output hfd_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_PRUNE_RD  = 7'b0000010,
		S_PRUNE_CHK = 7'b0000100,
		S_SCAN_RD   = 7'b0001000,
		S_SCAN_CHK  = 7'b0010000,
		S_STORE     = 7'b0100000,
		S_DONE      = 7'b1000000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.changed ? S_PRUNE_RD : S_DONE;
				end
			end
			S_PRUNE_RD: begin
				if (status.count_zero) begin
					state_d = S_SCAN_RD;
				end else begin
					cmd.prune_rd = 1'b1;
					state_d      = S_PRUNE_CHK;
				end
			end
			S_PRUNE_CHK: begin
				if (status.older) begin
					cmd.prune_pop = 1'b1;
					state_d       = S_PRUNE_RD;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (status.scan_more) begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_CHK;
				end else begin
					state_d = S_STORE;
				end
			end
			S_SCAN_CHK: begin
				cmd.scan_step = 1'b1;
				state_d       = S_SCAN_RD;
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/hfd_datapath.sv
// ----------------------------------------------------------------------------
// Health flap detector datapath
// Configuration, round state, timestamp ring memory and result registers.
// ----------------------------------------------------------------------------
`include "health_flap_detector_defines.svh"

module hfd_datapath
	import hfd_pkg::*;
#(
	parameter int MAX_CHANGES = MAX_CHANGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        any_up,
	input  logic        any_down,
	input  logic [31:0] now_seconds,
	input  hfd_cmd_t    cmd,
	output hfd_status_t status,
	output logic [2:0]  health_state,
	output logic        report_valid,
	output logic [2:0]  report_from,
	output logic [2:0]  report_to,
	output logic [4:0]  changes_in_window
);

	localparam int IDX_W = $clog2(MAX_CHANGES);
	localparam int CNT_W = $clog2(MAX_CHANGES + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	// Configuration and persistent state.
	logic [15:0]      window_q;
	logic [4:0]       thr_q;
	hstate_t          cur_state_q;
	logic             flap_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;

	// Per-round working registers.
	logic             up_q, down_q, changed_q, present_q;
	logic [31:0]      now_q, cutoff_q;
	logic [CNT_W-1:0] scan_k_q;

	// Timestamp ring.
	logic [31:0]      mem [MAX_CHANGES];
	logic [31:0]      rd_data_q;
	logic [IDX_W-1:0] rd_addr, wr_addr, ring_k, ring_cnt, oldest_inc;
	logic             wr_en, full;

	hstate_t          derived_in, derived_q, ns_c, rf_c, rt_c;
	logic             rv_c, fl_c;
	logic [31:0]      cutoff_in;
	logic [CMP_W-1:0] cnt_ext;

	function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
		logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(off);
		if (s >= SUM_W'(MAX_CHANGES)) begin
			s = s - SUM_W'(MAX_CHANGES);
		end
		return s[IDX_W-1:0];
	endfunction

	assign derived_in = derive_state(any_up, any_down);
	assign derived_q  = derive_state(up_q, down_q);
	assign cutoff_in  = (now_seconds >= {16'd0, window_q}) ?
		(now_seconds - {16'd0, window_q}) : 32'd0;

	assign ring_k     = ring_add(oldest_q, scan_k_q);
	assign ring_cnt   = ring_add(oldest_q, count_q);
	assign oldest_inc = ring_add(oldest_q, CNT_W'(1));
	assign full       = (count_q == CNT_W'(MAX_CHANGES));

	assign rd_addr = cmd.prune_rd ? oldest_q : ring_k;
	assign wr_en   = cmd.store && !present_q;
	assign wr_addr = full ? oldest_q : ring_cnt;

	assign status.changed    = (derived_in != cur_state_q) && (cur_state_q != ST_UNKNOWN);
	assign status.count_zero = (count_q == '0);
	assign status.older      = (rd_data_q < cutoff_q);
	assign status.scan_more  = (scan_k_q < count_q);

	assign cnt_ext = CMP_W'(count_q);

	// Outcome of the round once the store is up to date.
	always_comb begin
		ns_c = derived_q;
		rv_c = 1'b0;
		rf_c = ST_UNKNOWN;
		rt_c = ST_UNKNOWN;
		fl_c = flap_q;
		if (changed_q) begin
			if (cnt_ext > CMP_W'(thr_q)) begin
				ns_c = ST_SLOW_FLAP;
				fl_c = 1'b1;
				if (!flap_q) begin
					rv_c = 1'b1;
					rf_c = cur_state_q;
					rt_c = ST_SLOW_FLAP;
				end
			end else begin
				rv_c = 1'b1;
				rf_c = cur_state_q;
				rt_c = derived_q;
				fl_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= now_q;
		end
		if (cmd.prune_rd || cmd.scan_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			thr_q       <= THRESHOLD_RESET;
			cur_state_q <= ST_UNKNOWN;
			flap_q      <= 1'b0;
			oldest_q    <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WINDOW:    window_q <= cfg_wdata;
					REG_THRESHOLD: thr_q    <= cfg_wdata[4:0];
					default:       ;
				endcase
			end
			if (cmd.prune_pop) begin
				oldest_q <= oldest_inc;
				count_q  <= count_q - CNT_W'(1);
			end
			if (wr_en) begin
				if (full) begin
					oldest_q <= oldest_inc;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.out_load) begin
				cur_state_q <= ns_c;
				flap_q      <= fl_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			up_q      <= any_up;
			down_q    <= any_down;
			now_q     <= now_seconds;
			cutoff_q  <= cutoff_in;
			changed_q <= status.changed;
			scan_k_q  <= '0;
			present_q <= 1'b0;
		end
		if (cmd.scan_step) begin
			present_q <= present_q || (rd_data_q == now_q);
			scan_k_q  <= scan_k_q + CNT_W'(1);
		end
		if (cmd.out_load) begin
			health_state      <= ns_c;
			report_valid      <= rv_c;
			report_from       <= rf_c;
			report_to         <= rt_c;
			changes_in_window <= cnt_ext[4:0];
		end
	end

	`HFD_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_CHANGES))
	`HFD_ASSERT_IMP(a_pop_nonempty, clk, arst_n, cmd.prune_pop, count_q != '0)
	`HFD_ASSERT_NXT(a_store_grows, clk, arst_n, wr_en && !full,
		count_q == $past(count_q) + CNT_W'(1))
	`HFD_ASSERT_NXT(a_flap_forces_slow, clk, arst_n,
		cmd.out_load && changed_q && (cnt_ext > CMP_W'(thr_q)),
		cur_state_q == ST_SLOW_FLAP && flap_q)

endmodule

FILE: rtl/core/health_flap_detector.sv
// ----------------------------------------------------------------------------
// Health flap detector
// Sliding-window state flap detection for one monitored host.
// ----------------------------------------------------------------------------
// Each input item is one check round (any_up, any_down, now_seconds) on the
// in_ch channel; each round yields exactly one result item on out_ch with the
// new health state, an optional transition report and the number of change
// timestamps held in the window. Both channels move an item when valid and
// ready are high at a rising clock edge.
// A round that keeps its state, or leaves the unknown state, goes from
// acceptance straight to the hand-off. A counted change walks the timestamp
// ring through a single-port memory with a registered read: it drops stale
// entries from the oldest end, each read and then checked, until an entry is
// fresh or the ring runs empty, checks each remaining entry for a duplicate,
// stores the stamp unless it was found, and hands the result off. A new round
// is taken as soon as the controller is idle, even while the previous result
// still waits in the output register; the final hand-off waits for that
// register to empty. Reset (arst_n low) returns the state to unknown, clears
// flapping, empties the ring and restores window_seconds to 300 and
// flap_threshold to 2. The configuration port is to be written by the user
// only while no round is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module health_flap_detector
	import hfd_pkg::*;
#(
	parameter int MAX_CHANGES = MAX_CHANGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hfd_in_if.sink      in_ch,
	hfd_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Command and status between the sequencer and the datapath.
	hfd_cmd_t    cmd;
	hfd_status_t status;

	hfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	hfd_datapath #(
		.MAX_CHANGES (MAX_CHANGES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.any_up            (in_ch.any_up),
		.any_down          (in_ch.any_down),
		.now_seconds       (in_ch.now_seconds),
		.cmd               (cmd),
		.status            (status),
		.health_state      (out_ch.health_state),
		.report_valid      (out_ch.report_valid),
		.report_from       (out_ch.report_from),
		.report_to         (out_ch.report_to),
		.changes_in_window (out_ch.changes_in_window)
	);

endmodule

FILE: bench/tb_health_flap_detector.sv
// ----------------------------------------------------------------------------
// Health flap detector testbench
// Drives check rounds into the detector under random valid/ready idling and
// compares every round result with a typed-in value or a built-in model of the flap window.
// ----------------------------------------------------------------------------
// The run opens with a short directed table that walks the state codes, the
// flapping entry and exit, duplicate stamps, time going backwards, the top of
// the time range and a zero window. Rows whose result is obvious carry it
// typed in; the others are checked against the model. A series of random
// phases follows, each under its own window and threshold, with mostly
// slowly advancing time and some jumps, so the stamp ring fills, wraps and
// empties. Configuration is only written once every result has come back.
// ----------------------------------------------------------------------------
module tb_health_flap_detector;
	import hfd_pkg::*;

	localparam int RING_DEPTH = MAX_CHANGES_DEF;
	localparam int QUIET_LIMIT = 2000;	// cycles with no item moving on either side
	localparam int HOLD_CYCLES = 150;	// one long output hold-off
	localparam int DRAIN_CYCLES = 80;	// extra wait after the last result before the verdict

	// Kinds of rows in the directed table.
	typedef enum logic [1:0] {
		ROW_ROUND     = 2'd0,
		ROW_SET_WIN   = 2'd1,
		ROW_SET_THR   = 2'd2
	} row_kind_t;

	typedef struct packed {
		hstate_t    state;
		logic       report;
		hstate_t    src_state;
		hstate_t    dst_state;
		logic [4:0] count;
	} round_result_t;

	typedef struct packed {
		row_kind_t     kind;
		logic          up;
		logic          dn;
		logic [31:0]   t;
		logic [15:0]   value;
		logic          typed;
		round_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_wdata;

	hfd_in_if  in_ch ();
	hfd_out_if out_ch ();

	health_flap_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Model of the detector: configuration copy, round state and stamp ring.
	logic [15:0] det_window;
	logic [4:0]  det_threshold;
	hstate_t     det_state;
	logic        det_flapping;
	logic [31:0] stamps [RING_DEPTH];
	int          oldest_slot;
	int          stamp_count;

	// Round results that the block still owes, oldest first.
	round_result_t pending_results [$];

	int  mismatches;
	int  results_seen;
	int  rounds_sent;
	int  quiet_cycles;
	bit  steady_tail;	// no idling on either side in the last phase
	bit  hold_request;	// asks the receiver for one long hold-off

	stim_row_t directed_rows [0:25];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Drops stale stamps from the oldest end, then adds the current second
	// unless it is stored already. A full ring loses its oldest stamp.
	function automatic void log_change(logic [31:0] t);
		logic [31:0] cutoff;
		bit seen;
		int k;
		cutoff = (t >= {16'd0, det_window}) ? t - {16'd0, det_window} : 32'd0;
		while (stamp_count > 0 && stamps[oldest_slot] < cutoff) begin
			oldest_slot = (oldest_slot + 1) % RING_DEPTH;
			stamp_count--;
		end
		// The duplicate search covers every stored stamp, since time may
		// have gone backwards and left the ring out of order.
		seen = 1'b0;
		for (k = 0; k < stamp_count; k++) begin
			if (stamps[(oldest_slot + k) % RING_DEPTH] == t) begin
				seen = 1'b1;
			end
		end
		if (seen) begin
			return;
		end
		if (stamp_count < RING_DEPTH) begin
			stamps[(oldest_slot + stamp_count) % RING_DEPTH] = t;
			stamp_count++;
		end else begin
			stamps[oldest_slot] = t;
			oldest_slot = (oldest_slot + 1) % RING_DEPTH;
		end
	endfunction

	// Advances the model by one round and returns the result it should give.
	function automatic round_result_t predict_round(logic up, logic dn, logic [31:0] t);
		round_result_t r;
		hstate_t prior;
		hstate_t nxt;
		prior = det_state;
		if (up && dn) begin
			nxt = ST_FAST_FLAP;
		end else if (up) begin
			nxt = ST_UP;
		end else if (dn) begin
			nxt = ST_DOWN;
		end else begin
			nxt = ST_UNKNOWN;
		end
		r.report = 1'b0;
		r.src_state = ST_UNKNOWN;
		r.dst_state = ST_UNKNOWN;
		// Leaving unknown is neither counted nor reported. Slow flap never
		// comes from the probes, so every round taken in it is a change.
		if (nxt != prior && prior != ST_UNKNOWN) begin
			log_change(t);
			if (stamp_count > det_threshold) begin
				if (!det_flapping) begin
					r.report = 1'b1;
					r.src_state = prior;
					r.dst_state = ST_SLOW_FLAP;
				end
				nxt = ST_SLOW_FLAP;
				det_flapping = 1'b1;
			end else begin
				r.report = 1'b1;
				r.src_state = prior;
				r.dst_state = nxt;
				det_flapping = 1'b0;
			end
		end
		det_state = nxt;
		r.state = nxt;
		r.count = 5'(stamp_count);
		return r;
	endfunction

	function automatic stim_row_t round_row(logic up, logic dn, logic [31:0] t);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ROUND;
		row.up = up;
		row.dn = dn;
		row.t = t;
		return row;
	endfunction

	function automatic stim_row_t known_row(logic up, logic dn, logic [31:0] t, hstate_t st,
		logic rep, hstate_t src, hstate_t dst, logic [4:0] cnt);
		stim_row_t row;
		row = round_row(up, dn, t);
		row.typed = 1'b1;
		row.want.state = st;
		row.want.report = rep;
		row.want.src_state = src;
		row.want.dst_state = dst;
		row.want.count = cnt;
		return row;
	endfunction

	function automatic stim_row_t reg_row(row_kind_t kind, logic [15:0] value);
		stim_row_t row;
		row = '0;
		row.kind = kind;
		row.value = value;
		return row;
	endfunction

	// Prints one line per mismatch and counts every one.
	task automatic flag_error(string msg);
		mismatches++;
		$display("result %0d: %s", results_seen, msg);
	endtask

	// Result side: compare every accepted result with the oldest expectation,
	// and count cycles in which no item moves for the watchdog.
	always @(posedge clk) begin
		round_result_t want;
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_error("result arrived with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (out_ch.health_state !== want.state) begin
					flag_error($sformatf("health_state %0d, expected %0d",
						out_ch.health_state, want.state));
				end
				if (out_ch.report_valid !== want.report) begin
					flag_error($sformatf("report_valid %0d, expected %0d",
						out_ch.report_valid, want.report));
				end
				if (out_ch.report_from !== want.src_state) begin
					flag_error($sformatf("report_from %0d, expected %0d",
						out_ch.report_from, want.src_state));
				end
				if (out_ch.report_to !== want.dst_state) begin
					flag_error($sformatf("report_to %0d, expected %0d",
						out_ch.report_to, want.dst_state));
				end
				if (out_ch.changes_in_window !== want.count) begin
					flag_error($sformatf("changes_in_window %0d, expected %0d",
						out_ch.changes_in_window, want.count));
				end
			end
			results_seen++;
		end
	end

	// The watchdog ends a run that has stopped moving.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("tb_health_flap_detector NOT OK");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off on request, and no
	// stalls at all in the last phase. Ready changes only at the falling edge.
	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				// Hold long enough for the block to fill and refuse new rounds.
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
				out_ch.ready = 1'b0;
				stall = $urandom_range(1, 7) - 1;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// Offers one round, waits for it to be taken and records what it should
	// give. Called and left at a falling edge; valid stays high for the next
	// round unless a gap is drawn.
	task automatic send_round(input logic up, input logic dn, input logic [31:0] t,
		input logic typed, input round_result_t want);
		round_result_t r;
		if (!steady_tail && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.any_up = up;
		in_ch.any_down = dn;
		in_ch.now_seconds = t;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		// Accepted at this edge. The model always advances; a typed-in row
		// replaces the model's answer with the value from the table.
		r = predict_round(up, dn, t);
		pending_results.push_back(typed ? want : r);
		rounds_sent++;
		@(negedge clk);
	endtask

	// Lets every owed result come back before the block is touched again.
	task automatic wait_all_results();
		in_ch.valid = 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_WINDOW) begin
			det_window = val;
		end else begin
			det_threshold = val[4:0];
		end
	endtask

	// One phase of random rounds under a fixed window and threshold. Time
	// mostly creeps forward so changes pile up inside the window; now and
	// then it steps across the window, jumps anywhere, or runs backwards.
	task automatic random_phase(input logic [15:0] win, input logic [4:0] thr, input int n);
		logic [31:0] t;
		int k;
		int pick;
		wait_all_results();
		write_reg(REG_WINDOW, win);
		write_reg(REG_THRESHOLD, {11'd0, thr});
		t = $urandom;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				t = $urandom;
			end else if (pick == 1) begin
				t = t - $urandom_range(1, 50);
			end else if (pick <= 4) begin
				t = t + $urandom_range(0, 2 * int'(win) + 1);
			end else begin
				t = t + $urandom_range(0, 3);
			end
			if (rounds_sent == 100) begin
				hold_request = 1'b1;
			end
			send_round(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t, 1'b0, '0);
		end
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WINDOW;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.any_up = 1'b0;
		in_ch.any_down = 1'b0;
		in_ch.now_seconds = '0;
		mismatches = 0;
		results_seen = 0;
		rounds_sent = 0;
		quiet_cycles = 0;
		steady_tail = 1'b0;
		hold_request = 1'b0;
		det_window = WINDOW_RESET;
		det_threshold = THRESHOLD_RESET;
		det_state = ST_UNKNOWN;
		det_flapping = 1'b0;
		oldest_slot = 0;
		stamp_count = 0;

		// Directed table, starting from the reset window of 300 s and a
		// threshold of 2.
		directed_rows = '{
			// Unknown stays unknown; leaving unknown is not counted.
			known_row(0, 0, 32'd0, ST_UNKNOWN, 0, ST_UNKNOWN, ST_UNKNOWN, 5'd0),
			known_row(1, 0, 32'd10, ST_UP, 0, ST_UNKNOWN, ST_UNKNOWN, 5'd0),
			known_row(1, 0, 32'd10, ST_UP, 0, ST_UNKNOWN, ST_UNKNOWN, 5'd0),
			known_row(0, 1, 32'd20, ST_DOWN, 1, ST_UP, ST_DOWN, 5'd1),
			// Same second again: the stamp is not stored twice.
			known_row(1, 1, 32'd20, ST_FAST_FLAP, 1, ST_DOWN, ST_FAST_FLAP, 5'd1),
			known_row(1, 0, 32'd30, ST_UP, 1, ST_FAST_FLAP, ST_UP, 5'd2),
			// Third change exceeds the threshold: flapping begins, reported once.
			known_row(0, 1, 32'd40, ST_SLOW_FLAP, 1, ST_UP, ST_SLOW_FLAP, 5'd3),
			known_row(1, 0, 32'd50, ST_SLOW_FLAP, 0, ST_UNKNOWN, ST_UNKNOWN, 5'd4),
			// Same probes again still count, since slow flap is never derived.
			known_row(1, 0, 32'd50, ST_SLOW_FLAP, 0, ST_UNKNOWN, ST_UNKNOWN, 5'd4),
			known_row(0, 0, 32'd60, ST_SLOW_FLAP, 0, ST_UNKNOWN, ST_UNKNOWN, 5'd5),
			// Everything ages out of the window and flapping ends.
			known_row(1, 0, 32'd4000, ST_UP, 1, ST_SLOW_FLAP, ST_UP, 5'd1),
			// Time runs backwards; the cutoff saturates at zero.
			known_row(0, 1, 32'd100, ST_DOWN, 1, ST_UP, ST_DOWN, 5'd2),
			// Pruning stops at the fresh oldest stamp even though a stale one
			// sits behind it; the duplicate test still finds 4000.
			known_row(1, 0, 32'd4000, ST_UP, 1, ST_DOWN, ST_UP, 5'd2),
			known_row(0, 1, 32'hFFFF_FFFF, ST_DOWN, 1, ST_UP, ST_DOWN, 5'd1),
			known_row(0, 0, 32'hFFFF_FFFF, ST_UNKNOWN, 1, ST_DOWN, ST_UNKNOWN, 5'd1),
			known_row(1, 0, 32'hFFFF_FFFF, ST_UP, 0, ST_UNKNOWN, ST_UNKNOWN, 5'd1),
			// Zero threshold and zero window: the cutoff is the current second.
			reg_row(ROW_SET_THR, 16'd0),
			reg_row(ROW_SET_WIN, 16'd0),
			known_row(0, 1, 32'hFFFF_FFFF, ST_SLOW_FLAP, 1, ST_UP, ST_SLOW_FLAP, 5'd1),
			round_row(1, 1, 32'd5),
			// Widest window and a threshold that can never be exceeded.
			reg_row(ROW_SET_WIN, 16'hFFFF),
			reg_row(ROW_SET_THR, 16'd16),
			round_row(0, 1, 32'd6),
			round_row(1, 0, 32'd7),
			round_row(1, 1, 32'd8),
			round_row(0, 0, 32'd9)
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < $size(directed_rows); k++) begin
			case (directed_rows[k].kind)
				ROW_SET_WIN: begin
					wait_all_results();
					write_reg(REG_WINDOW, directed_rows[k].value);
				end
				ROW_SET_THR: begin
					wait_all_results();
					write_reg(REG_THRESHOLD, directed_rows[k].value);
				end
				default: begin
					send_round(directed_rows[k].up, directed_rows[k].dn, directed_rows[k].t,
						directed_rows[k].typed, directed_rows[k].want);
				end
			endcase
		end

		// Random phases; each drains before its registers are rewritten,
		// which is also the sender's pause until every result is back.
		random_phase(16'd300, 5'd2, 190);
		random_phase(16'd1, 5'd0, 190);
		random_phase(16'hFFFF, 5'd16, 190);
		random_phase(16'd0, 5'd1, 190);
		random_phase(16'd60, 5'd3, 190);
		random_phase(16'd5, 5'd16, 190);
		random_phase(16'd20, 5'd6, 190);
		steady_tail = 1'b1;
		random_phase(16'($urandom_range(1, 65535)), 5'($urandom_range(0, 16)), 190);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_health_flap_detector OK");
		end else begin
			$display("tb_health_flap_detector NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/hfd_pkg.sv
rtl/core/hfd_in_if.sv
rtl/core/hfd_out_if.sv
rtl/core/hfd_ctrl.sv
rtl/core/hfd_datapath.sv
rtl/core/health_flap_detector.sv
bench/tb_health_flap_detector.sv
